[hw/rtl/cvce_pkg.sv]
package cvce_pkg;

    // geometry of the doubled grid
    localparam int MAX_SIDE = 32;
    localparam int GRID     = 2 * MAX_SIDE + 1;
    localparam int DEPTH    = GRID * GRID * GRID;
    localparam int AW       = $clog2(DEPTH);
    localparam int MW       = AW + 1;
    localparam int NW       = $clog2(MAX_SIDE + 1);
    localparam int DW       = $clog2(GRID + 2);

    // port field widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int VOX_W      = 15;
    localparam int VAL_W      = 8;
    localparam int CUBE_W     = 19;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRIMAL = 2'd3;

    // opcodes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_MARK  = 2'd1;
    localparam logic [1:0] OP_BND   = 2'd2;
    localparam logic [1:0] OP_COBND = 2'd3;

    typedef logic [DW-1:0] t_coord;
    typedef logic [AW-1:0] t_addr;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [VOX_W-1:0]  voxel_index;
        logic [VAL_W-1:0]  voxel_value;
        logic [CUBE_W-1:0] cube_index;
    } t_in;

    typedef struct packed {
        logic              entry_present;
        logic [CUBE_W-1:0] neighbor_index;
        logic              neighbor_in_range;
        logic              cube_member;
        logic [1:0]        cube_dim;
        logic              last;
    } t_out;

    // clamped sizes and derived extents
    typedef struct packed {
        logic [2:0][NW-1:0] n;
        logic [2:0][DW-1:0] d;
        logic [2:0][DW-1:0] hi;
        logic               p;
    } t_geom;

    // classified item handed from front to back
    typedef struct packed {
        logic [1:0]       op;
        logic             act;
        t_coord           x;
        t_coord           y;
        t_coord           z;
        t_addr            center;
        logic [DW-1:0]    acc1;
        logic [2*DW-1:0]  acc2;
    } t_cmd;

    typedef enum logic [2:0] {
        F_IDLE, F_PROD1, F_PROD2, F_CHECK, F_DIV1, F_DIV2, F_ADDR1, F_ADDR2
    } t_fstate;

    typedef enum logic [3:0] {
        B_CLEAR, B_IDLE, B_MARK, B_ACK, B_QRD, B_QWAIT, B_NRD, B_NEV, B_DONE,
        B_PUSHW
    } t_bstate;

    function automatic logic [NW-1:0] clamp_size(input logic [CFG_DATA_W-1:0] r);
        logic [NW-1:0] v;
        if (r == '0) begin
            v = NW'(1);
        end else if (r > CFG_DATA_W'(MAX_SIDE)) begin
            v = NW'(MAX_SIDE);
        end else begin
            v = NW'(r);
        end
        return v;
    endfunction

endpackage

[hw/rtl/cvce_div.sv]
module cvce_div import cvce_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_addr         i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output t_addr         o_quo,
    output logic [DW-1:0] o_rem
);

    localparam int CW = $clog2(AW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    t_addr         r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_sh;
    logic          w_ge;

    // one quotient bit per cycle, restoring
    assign w_sh = {r_rem, r_quo[AW-1]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && (r_cnt == CW'(1));
            if (i_start) begin
                r_cnt <= CW'(AW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[AW-2:0], w_ge};
            r_rem <= w_ge ? DW'(w_sh - {1'b0, r_den}) : w_sh[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

[hw/rtl/cvce_front.sv]
module cvce_front import cvce_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_go,
    input  t_in   i_item,
    input  t_geom i_geom,
    input  logic  i_full,
    output logic  o_busy,
    output logic  o_push,
    output t_cmd  o_cmd
);

    t_fstate          r_state, n_state;
    t_in              r_in;
    logic [2*NW-1:0]  r_nn;
    logic [3*NW-1:0]  r_nvox;
    logic [2*DW-1:0]  r_acc2;
    logic [3*DW-1:0]  r_total;
    logic             r_act;
    t_coord           r_x, r_y, r_z;
    logic [2*DW-1:0]  r_t1;
    logic [3*DW-1:0]  r_t2;
    t_addr            r_center;

    logic             w_mark, w_act, w_div_start, w_done;
    t_addr            w_num, w_quo;
    logic [DW-1:0]    w_den, w_rem;
    t_coord           w_rcoord, w_zcoord;
    logic             w_pushing;

    assign w_mark = (r_in.opcode == OP_MARK);

    // item classification: occupied voxel inside the grid, or cube inside the map
    always_comb begin
        if (w_mark) begin
            w_act = (r_in.voxel_value != '0) &&
                    ((3*NW+VOX_W)'(r_in.voxel_index) < (3*NW+VOX_W)'(r_nvox));
        end else begin
            w_act = ((3*DW+CUBE_W)'(r_in.cube_index) < (3*DW+CUBE_W)'(r_total));
        end
    end

    // shared divider operands
    always_comb begin
        if (r_state == F_CHECK) begin
            w_num = w_mark ? AW'(r_in.voxel_index) : AW'(r_in.cube_index);
            w_den = w_mark ? DW'(i_geom.n[0]) : i_geom.d[0];
        end else begin
            w_num = w_quo;
            w_den = w_mark ? DW'(i_geom.n[1]) : i_geom.d[1];
        end
    end

    cvce_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // voxel coordinate to cube coordinate for a mark; a query already carries cube coordinates
    assign w_rcoord = w_mark ? t_coord'({w_rem[DW-2:0], i_geom.p}) : w_rem;
    assign w_zcoord = w_mark ? t_coord'({w_quo[DW-2:0], i_geom.p}) : t_coord'(w_quo);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_go) n_state = F_PROD1;
            F_PROD1: n_state = (r_in.opcode == OP_CLEAR) ? F_ADDR2 : F_PROD2;
            F_PROD2: n_state = F_CHECK;
            F_CHECK: n_state = w_act ? F_DIV1 : F_ADDR2;
            F_DIV1:  if (w_done) n_state = F_DIV2;
            F_DIV2:  if (w_done) n_state = w_mark ? F_ADDR1 : F_ADDR2;
            F_ADDR1: n_state = F_ADDR2;
            F_ADDR2: if (w_pushing) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        w_div_start = 1'b0;
        w_pushing   = 1'b0;
        case (r_state)
            F_CHECK: w_div_start = w_act;
            F_DIV1:  w_div_start = w_done;
            F_ADDR2: w_pushing   = !i_full && !(w_mark && r_act && r_center == '1);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (i_go) begin
                    r_in <= i_item;
                end
                r_act <= 1'b0;
            end
            F_PROD1: begin
                r_nn   <= i_geom.n[0] * i_geom.n[1];
                r_acc2 <= i_geom.d[0] * i_geom.d[1];
                r_x    <= '0;
                r_y    <= '0;
                r_z    <= '0;
            end
            F_PROD2: begin
                r_nvox  <= r_nn * i_geom.n[2];
                r_total <= r_acc2 * i_geom.d[2];
            end
            F_CHECK: begin
                r_act    <= w_act;
                // all ones marks a mark center still to be computed
                r_center <= w_mark ? '1 : t_addr'(r_in.cube_index);
            end
            F_DIV1: begin
                if (w_done) r_x <= w_rcoord;
            end
            F_DIV2: begin
                if (w_done) begin
                    r_y <= w_rcoord;
                    r_z <= w_zcoord;
                end
            end
            F_ADDR1: begin
                r_t1 <= i_geom.d[0] * r_y;
                r_t2 <= r_acc2 * r_z;
            end
            F_ADDR2: begin
                if (w_mark && r_act && r_center == '1) begin
                    r_center <= AW'(r_x) + AW'(r_t1) + AW'(r_t2);
                end
            end
            default: ;
        endcase
    end

    assign o_busy      = (r_state != F_IDLE);
    assign o_push      = w_pushing;
    assign o_cmd.op    = r_in.opcode;
    assign o_cmd.act   = r_act;
    assign o_cmd.x     = r_x;
    assign o_cmd.y     = r_y;
    assign o_cmd.z     = r_z;
    assign o_cmd.center = r_center;
    assign o_cmd.acc1  = i_geom.d[0];
    assign o_cmd.acc2  = r_acc2;

endmodule

[hw/rtl/cvce_fifo.sv]
module cvce_fifo import cvce_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    // two-entry command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

endmodule

[hw/rtl/cvce_back.sv]
module cvce_back import cvce_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_cmd  i_cmd,
    input  t_geom i_geom,
    output logic  o_pop,
    output logic  o_init,
    output logic  o_strobe,
    output t_out  o_res
);

    t_bstate       r_state, n_state;
    t_cmd          r_cmd;
    t_addr         r_clr;
    logic          r_fill;
    logic          r_init;
    logic [MW-1:0] r_addr;
    logic [1:0]    r_dx, r_dy, r_dz;
    logic [2:0]    r_k;
    logic          r_mem;
    logic          r_rd;
    t_addr         r_nb;
    logic          r_ok, r_par;
    logic          r_pend;
    t_out          r_pres;
    logic          r_strobe;
    t_out          r_res;

    logic          map [DEPTH];

    logic          w_we, w_wdata, w_pt_ok, w_last_pt;
    t_addr         w_waddr, w_raddr;
    logic [DW:0]   w_px, w_py, w_pz;
    logic [1:0]    w_axis;
    t_coord        w_co;
    logic [DW-1:0] w_hi;
    t_addr         w_acc, w_nb;
    logic          w_plus, w_ok, w_par, w_qual;
    logic [1:0]    w_dim;

    // bounds of the current point of a mark
    assign w_px = {1'b0, r_cmd.x} + (DW+1)'(r_dx);
    assign w_py = {1'b0, r_cmd.y} + (DW+1)'(r_dy);
    assign w_pz = {1'b0, r_cmd.z} + (DW+1)'(r_dz);
    assign w_pt_ok = (w_px != '0) && (w_px <= {1'b0, i_geom.hi[0]}) &&
                     (w_py != '0) && (w_py <= {1'b0, i_geom.hi[1]}) &&
                     (w_pz != '0) && (w_pz <= {1'b0, i_geom.hi[2]});
    assign w_last_pt = (r_dx == 2'd2) && (r_dy == 2'd2) && (r_dz == 2'd2);

    // neighbour along axis k/2, upward for even k
    assign w_axis = r_k[2:1];
    assign w_plus = !r_k[0];
    always_comb begin
        case (w_axis)
            2'd0: begin
                w_co  = r_cmd.x;
                w_hi  = i_geom.hi[0];
                w_acc = AW'(1);
            end
            2'd1: begin
                w_co  = r_cmd.y;
                w_hi  = i_geom.hi[1];
                w_acc = AW'(r_cmd.acc1);
            end
            default: begin
                w_co  = r_cmd.z;
                w_hi  = i_geom.hi[2];
                w_acc = AW'(r_cmd.acc2);
            end
        endcase
    end
    assign w_ok  = w_plus ? (({1'b0, w_co} + (DW+1)'(2)) <= {1'b0, w_hi}) : (w_co != '0);
    assign w_nb  = w_plus ? r_cmd.center + w_acc : r_cmd.center - w_acc;
    assign w_par = ((r_cmd.op == OP_BND) == w_co[0]);
    assign w_dim = 2'(r_cmd.x[0]) + 2'(r_cmd.y[0]) + 2'(r_cmd.z[0]);
    assign w_qual = (r_cmd.op == OP_BND) ? r_par : (r_par && r_ok && r_rd);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_CLEAR: begin
                if (r_clr == t_addr'(DEPTH - 1)) n_state = r_init ? B_IDLE : B_ACK;
            end
            B_IDLE: begin
                if (i_valid) begin
                    case (i_cmd.op)
                        OP_CLEAR: n_state = B_CLEAR;
                        OP_MARK:  n_state = i_cmd.act ? B_MARK : B_ACK;
                        default:  n_state = i_cmd.act ? B_QRD : B_DONE;
                    endcase
                end
            end
            B_MARK:  if (w_last_pt) n_state = B_ACK;
            B_ACK:   n_state = B_IDLE;
            B_QRD:   n_state = B_QWAIT;
            B_QWAIT: n_state = B_NRD;
            B_NRD:   n_state = B_NEV;
            B_NEV:   n_state = (r_k == 3'd5) ? B_DONE : B_NRD;
            B_DONE:  n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // outputs toward queue and map
    always_comb begin
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_waddr = r_clr;
        w_wdata = r_fill;
        w_raddr = r_cmd.center;
        case (r_state)
            B_CLEAR: w_we = 1'b1;
            B_IDLE:  o_pop = i_valid;
            B_MARK: begin
                w_we    = w_pt_ok;
                w_waddr = r_addr[AW-1:0];
                w_wdata = i_geom.p;
            end
            B_NRD:   w_raddr = w_ok ? w_nb : r_cmd.center;
            default: ;
        endcase
    end

    // membership map, one bit per cube
    always_ff @(posedge i_clk) begin
        if (w_we) map[w_waddr] <= w_wdata;
        r_rd <= map[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLEAR;
            r_init   <= 1'b1;
            r_clr    <= '0;
            r_fill   <= 1'b0;
            r_strobe <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == B_ACK) || (r_state == B_DONE) ||
                        (r_state == B_NEV && w_qual && r_pend);
            case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == t_addr'(DEPTH - 1)) r_init <= 1'b0;
                end
                B_IDLE: begin
                    r_clr  <= '0;
                    r_fill <= ~i_geom.p;
                    r_pend <= 1'b0;
                end
                B_ACK, B_DONE: begin
                    r_pend   <= 1'b0;
                end
                B_NEV: begin
                    if (w_qual) begin
                        r_pend   <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_cmd  <= i_cmd;
                r_mem  <= 1'b0;
                r_k    <= '0;
                r_dx   <= '0;
                r_dy   <= '0;
                r_dz   <= '0;
                r_addr <= MW'(i_cmd.center) - MW'(1) - MW'(i_cmd.acc1) - MW'(i_cmd.acc2);
            end
            B_MARK: begin
                if (r_dx != 2'd2) begin
                    r_dx   <= r_dx + 2'd1;
                    r_addr <= r_addr + MW'(1);
                end else if (r_dy != 2'd2) begin
                    r_dx   <= '0;
                    r_dy   <= r_dy + 2'd1;
                    r_addr <= r_addr + MW'(r_cmd.acc1) - MW'(2);
                end else begin
                    r_dx   <= '0;
                    r_dy   <= '0;
                    r_dz   <= r_dz + 2'd1;
                    r_addr <= r_addr + MW'(r_cmd.acc2) - MW'(2) * MW'(r_cmd.acc1)
                              - MW'(2);
                end
            end
            B_QWAIT: r_mem <= r_rd;
            B_NRD: begin
                r_nb  <= w_ok ? w_nb : '0;
                r_ok  <= w_ok;
                r_par <= w_par;
            end
            B_NEV: begin
                r_k <= r_k + 3'd1;
                if (w_qual) begin
                    r_pres <= '{entry_present: 1'b1,
                                neighbor_index: CUBE_W'(r_nb),
                                neighbor_in_range: r_ok,
                                cube_member: r_mem,
                                cube_dim: w_dim,
                                last: 1'b0};
                    r_res  <= r_pres;
                end
            end
            B_ACK: r_res <= '{default: '0, last: 1'b1};
            B_DONE: begin
                if (r_pend) begin
                    r_res <= '{entry_present: r_pres.entry_present,
                               neighbor_index: r_pres.neighbor_index,
                               neighbor_in_range: r_pres.neighbor_in_range,
                               cube_member: r_pres.cube_member,
                               cube_dim: r_pres.cube_dim,
                               last: 1'b1};
                end else begin
                    r_res <= '{entry_present: 1'b0,
                               neighbor_index: '0,
                               neighbor_in_range: 1'b0,
                               cube_member: r_mem,
                               cube_dim: w_dim,
                               last: 1'b1};
                end
            end
            default: ;
        endcase
    end

    assign o_init   = r_init;
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // a mark never writes past the map
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_MARK && w_pt_ok) |-> (r_addr < MW'(DEPTH)))
        else $error("mark write outside map");

    // every item closes with a last result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_ACK || r_state == B_DONE) |=> (o_strobe && o_res.last))
        else $error("missing last result");

    // acknowledges carry no entry
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_ACK) |=> !o_res.entry_present)
        else $error("acknowledge with entry");

    // no item is taken while the map is swept after reset
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !o_pop)
        else $error("item taken during reset sweep");

endmodule

[hw/rtl/voxel_cubical_complex_engine_core.sv]
// Voxel cubical complex engine: a one-bit membership map over a doubled
// grid of up to 65 x 65 x 65 cubes, with clear, mark and neighbour queries.
// Items: present on i_item with start high; a transaction is taken at a
// rising edge with start high and busy low. Sizes and mode are written on
// the cfg channel (i_cfg_valid / o_cfg_ready, always ready) while idle.
// Results: o_result is valid for the one cycle o_strobe is high; there is
// no backpressure, o_result.last closes each item.
// Front end (decode, two restoring divisions, address multiply) takes one
// item at a time and stays busy until it pushes the item's command, waiting
// while the queue is full; a two-entry queue lets it run ahead of the back
// end. Back end, bound by the single map port: clear sweeps every cube of
// the map, mark visits the 27 cubes around its centre and writes the ones
// inside the grid, a query reads the cube, then its six neighbours.
// An entry is held until the next one is found or the list closes, and only
// then does its result appear.
// Reset: synchronous, active low; sizes reset to 1, mode to primal, and a
// zero sweep of the whole map follows, with busy high throughout.
module voxel_cubical_complex_engine_core import cvce_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in                   i_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_strobe,
    output t_out                  o_result
);

    logic [CFG_DATA_W-1:0] r_size_x, r_size_y, r_size_z;
    logic                  r_primal;
    t_geom                 w_geom;
    logic                  w_go, w_front_busy, w_push, w_full, w_valid, w_pop, w_init;
    t_cmd                  w_cmd_in, w_cmd_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= CFG_DATA_W'(1);
            r_size_y <= CFG_DATA_W'(1);
            r_size_z <= CFG_DATA_W'(1);
            r_primal <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SIZE_X: r_size_x <= i_cfg_data;
                REG_SIZE_Y: r_size_y <= i_cfg_data;
                REG_SIZE_Z: r_size_z <= i_cfg_data;
                REG_PRIMAL: r_primal <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped sizes and grid extents
    always_comb begin
        w_geom.n[0] = clamp_size(r_size_x);
        w_geom.n[1] = clamp_size(r_size_y);
        w_geom.n[2] = clamp_size(r_size_z);
        w_geom.p    = r_primal;
        for (int i = 0; i < 3; i++) begin
            w_geom.d[i]  = DW'({w_geom.n[i], 1'b1});
            w_geom.hi[i] = DW'({w_geom.n[i], 1'b0}) + DW'(r_primal);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = w_front_busy | w_init;
    assign w_go        = start & ~busy;

    cvce_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_item  (i_item),
        .i_geom  (w_geom),
        .i_full  (w_full),
        .o_busy  (w_front_busy),
        .o_push  (w_push),
        .o_cmd   (w_cmd_in)
    );

    cvce_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_valid),
        .o_cmd   (w_cmd_out)
    );

    cvce_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid),
        .i_cmd    (w_cmd_out),
        .i_geom   (w_geom),
        .o_pop    (w_pop),
        .o_init   (w_init),
        .o_strobe (o_strobe),
        .o_res    (o_result)
    );

endmodule
